// ===== rtl/pmsc_pkg.sv =====
// ----------------------------------------------------------------------------
// pmsc_pkg
// Shared widths, constants, types and helpers of the modulo step counter.
// ----------------------------------------------------------------------------
package pmsc_pkg;

	localparam int CHANNELS_DEF = 16;

	// serial multiplier: A x B, one bit of B per cycle
	localparam int MUL_A_W = 15;
	localparam int MUL_B_W = 14;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// serial divider: N / D, one quotient bit per cycle
	localparam int DIV_N_W = 25;
	localparam int DIV_D_W = 14;

	localparam int STEP_W  = 10;
	localparam int MV_W    = 15;
	localparam int LEVEL_W = 20;

	localparam logic signed [MV_W-1:0] GATE_HI = 15'sd2000;
	localparam logic signed [MV_W-1:0] GATE_LO = 15'sd100;

	localparam logic [DIV_D_W-1:0] SCALE_REL_DIV  = 14'd10000;
	localparam logic [DIV_D_W-1:0] SCALE_ABS_DIV  = 14'd1000;
	localparam logic [MUL_B_W-1:0] LVL_PER_STEP   = 14'd500;
	localparam logic [MUL_B_W-1:0] LVL_FULL_SCALE = 14'd10000;

	// register map, word index
	localparam logic [1:0] REG_STEPS_COUNT   = 2'd0;
	localparam logic [1:0] REG_HALF_STEP     = 2'd1;
	localparam logic [1:0] REG_SCALE_REL     = 2'd2;
	localparam logic [1:0] REG_OUT_PER_STEP  = 2'd3;

	localparam logic [STEP_W-1:0] STEPS_RESET = 10'd10;

	typedef struct packed {
		logic [STEP_W-1:0] step;
		logic              rst_armed;
		logic              inc_armed;
		logic              dec_armed;
	} chan_state_t;

	typedef struct packed {
		logic fire;
		logic armed;
	} gate_t;

	// hysteresis gate, fires on the arming edge
	function automatic gate_t schmitt(input logic armed, input logic signed [MV_W-1:0] mv);
		gate_t g;
		g.fire  = 1'b0;
		g.armed = armed;
		if (armed) begin
			if (mv <= GATE_LO) g.armed = 1'b0;
		end else if (mv >= GATE_HI) begin
			g.armed = 1'b1;
			g.fire  = 1'b1;
		end
		return g;
	endfunction

endpackage

// ===== rtl/pmsc_serial_mul.sv =====
// ----------------------------------------------------------------------------
// pmsc_serial_mul
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pmsc_serial_mul (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [pmsc_pkg::MUL_A_W-1:0]     op_a,
	input  logic [pmsc_pkg::MUL_B_W-1:0]     op_b,
	output logic                             done,
	output logic [pmsc_pkg::MUL_P_W-1:0]     product
);
	localparam int CNT_W = $clog2(pmsc_pkg::MUL_B_W);

	logic [pmsc_pkg::MUL_P_W-1:0] acc_q;
	logic [pmsc_pkg::MUL_P_W-1:0] mc_q;
	logic [pmsc_pkg::MUL_B_W-1:0] mp_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         busy_q;
	logic                         done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(pmsc_pkg::MUL_B_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mc_q  <= pmsc_pkg::MUL_P_W'(op_a);
			mp_q  <= op_b;
		end else if (busy_q) begin
			if (mp_q[0]) acc_q <= acc_q + mc_q;
			mc_q <= {mc_q[pmsc_pkg::MUL_P_W-2:0], 1'b0};
			mp_q <= {1'b0, mp_q[pmsc_pkg::MUL_B_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

// ===== rtl/pmsc_serial_div.sv =====
// ----------------------------------------------------------------------------
// pmsc_serial_div
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module pmsc_serial_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [pmsc_pkg::DIV_N_W-1:0]     dividend,
	input  logic [pmsc_pkg::DIV_D_W-1:0]     divisor,
	output logic                             done,
	output logic [pmsc_pkg::DIV_N_W-1:0]     quotient,
	output logic [pmsc_pkg::DIV_D_W-1:0]     remainder
);
	localparam int CNT_W = $clog2(pmsc_pkg::DIV_N_W);
	localparam int DW    = pmsc_pkg::DIV_D_W;
	localparam int NW    = pmsc_pkg::DIV_N_W;

	logic [NW-1:0]    quo_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      shifted;
	logic [DW+1:0]    diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign shifted = {rem_q, quo_q[NW-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

	// dividend bits leave at the top of quo_q while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[DW+1]) begin
				rem_q <= diff[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/pmsc_chan_store.sv =====
// ----------------------------------------------------------------------------
// pmsc_chan_store
// Per-channel step and gate state, one read and one write port.
// ----------------------------------------------------------------------------
module pmsc_chan_store #(
	parameter int CHANNELS = pmsc_pkg::CHANNELS_DEF,
	localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [IW-1:0]         rd_idx,
	output pmsc_pkg::chan_state_t rd_word,
	input  logic                  wr_en,
	input  logic [IW-1:0]         wr_idx,
	input  pmsc_pkg::chan_state_t wr_word
);
	pmsc_pkg::chan_state_t mem [CHANNELS];
	pmsc_pkg::chan_state_t rd_q;
	logic [CHANNELS-1:0]   valid_q;
	logic                  rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_idx] <= wr_word;
		if (rd_en) rd_q <= mem[rd_idx];
	end

	// unwritten entries read as the reset state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) valid_q[wr_idx] <= 1'b1;
			if (rd_en) rd_valid_q <= valid_q[rd_idx];
		end
	end

	assign rd_word = rd_valid_q ? rd_q : '0;

endmodule

// ===== rtl/poly_modulo_step_counter_unit.sv =====
// ----------------------------------------------------------------------------
// poly_modulo_step_counter_unit
// Per-channel up/down step counter with modulo wrap and level output.
// ----------------------------------------------------------------------------
// Sequence from input request to result valid: one store read, up to two serial
// multiplier runs and three serial divider runs, plus the sum, the level setup
// and the output write.
// Flow: one request at a time; the next is taken once the result is in the
// output register, which holds it while the sink stalls.
// Reset: steps_count 10, relative scale 1, others 0; all channel state zero.
module poly_modulo_step_counter_unit #(
	parameter int CHANNELS = pmsc_pkg::CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// channel[3:0], reset_mv[18:4], increment_mv[33:19], decrement_mv[48:34],
	// scale_mv[63:49]
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,
	// scale_present[0]
	input  logic        s_axis_tuser,
	// out_channel[3:0], step_index[13:4], step_size[28:14], level_mv[48:29],
	// zero[55:49]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SW = pmsc_pkg::STEP_W;
	localparam int MW = pmsc_pkg::MV_W;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_READ   = 4'd1;
	localparam logic [3:0] ST_SZ_MUL = 4'd2;
	localparam logic [3:0] ST_SZ_DIV = 4'd3;
	localparam logic [3:0] ST_SUM    = 4'd4;
	localparam logic [3:0] ST_MOD    = 4'd5;
	localparam logic [3:0] ST_LEVEL  = 4'd6;
	localparam logic [3:0] ST_LV_MUL = 4'd7;
	localparam logic [3:0] ST_LV_DIV = 4'd8;
	localparam logic [3:0] ST_FINISH = 4'd9;

	// configuration
	logic [SW-1:0] steps_count_q;
	logic          half_step_q;
	logic          scale_rel_q;
	logic          per_step_q;
	logic          cfg_wr;

	// request payload
	logic [3:0]           chan_q;
	logic [IW-1:0]        idx_q;
	logic signed [MW-1:0] rst_mv_q;
	logic signed [MW-1:0] inc_mv_q;
	logic signed [MW-1:0] dec_mv_q;
	logic signed [MW-1:0] scl_mv_q;
	logic                 present_q;

	// working state
	logic [3:0]           state_q;
	logic [SW-1:0]        n_q;
	logic [SW-1:0]        step_q;
	logic signed [MW-1:0] size_q;
	logic                 scl_neg_q;
	logic                 sum_neg_q;
	logic                 fr_q, fi_q, fd_q;
	logic [2:0]           arm_q;
	logic [pmsc_pkg::LEVEL_W-1:0] level_q;

	// output register
	logic        m_tvalid_q;
	logic [55:0] m_tdata_q;
	logic        out_free;

	// channel store
	logic [IW-1:0]         idx_lut [16];
	logic                  st_rd_en;
	pmsc_pkg::chan_state_t st_rd_word;
	logic                  st_wr_en;
	pmsc_pkg::chan_state_t st_wr_word;

	// arithmetic units
	logic                              mul_go_q;
	logic [pmsc_pkg::MUL_A_W-1:0]      mul_a_q;
	logic [pmsc_pkg::MUL_B_W-1:0]      mul_b_q;
	logic                              mul_done;
	logic [pmsc_pkg::MUL_P_W-1:0]      mul_p;
	logic                              div_go_q;
	logic [pmsc_pkg::DIV_N_W-1:0]      div_n_q;
	logic [pmsc_pkg::DIV_D_W-1:0]      div_d_q;
	logic                              div_done;
	logic [pmsc_pkg::DIV_N_W-1:0]      div_q;
	logic [pmsc_pkg::DIV_D_W-1:0]      div_r;

	// combinational helpers
	pmsc_pkg::gate_t      g_rst, g_inc, g_dec;
	logic [SW-1:0]        n_eff;
	logic [MW-1:0]        scl_mag;
	logic [MW-1:0]        size_mag;
	logic signed [15:0]   size_ext;
	logic signed [15:0]   delta;
	logic signed [15:0]   sum;
	logic [15:0]          sum_mag;
	logic [SW-1:0]        rem_s;
	logic [SW:0]          twice;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_count_q <= pmsc_pkg::STEPS_RESET;
			half_step_q   <= 1'b0;
			scale_rel_q   <= 1'b1;
			per_step_q    <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				pmsc_pkg::REG_STEPS_COUNT:  steps_count_q <= pwdata[SW-1:0];
				pmsc_pkg::REG_HALF_STEP:    half_step_q   <= pwdata[0];
				pmsc_pkg::REG_SCALE_REL:    scale_rel_q   <= pwdata[0];
				pmsc_pkg::REG_OUT_PER_STEP: per_step_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			pmsc_pkg::REG_STEPS_COUNT:  prdata = 32'(steps_count_q);
			pmsc_pkg::REG_HALF_STEP:    prdata = 32'(half_step_q);
			pmsc_pkg::REG_SCALE_REL:    prdata = 32'(scale_rel_q);
			pmsc_pkg::REG_OUT_PER_STEP: prdata = 32'(per_step_q);
			default:                    prdata = '0;
		endcase
	end

	// ---------------- channel store ----------------
	for (genvar g = 0; g < 16; g++) begin : g_idx
		assign idx_lut[g] = IW'(g % CHANNELS);
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign st_rd_en      = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_tvalid_q || m_axis_tready;
	assign st_wr_en      = (state_q == ST_FINISH) && out_free;

	assign st_wr_word.step      = step_q;
	assign st_wr_word.rst_armed = arm_q[2];
	assign st_wr_word.inc_armed = arm_q[1];
	assign st_wr_word.dec_armed = arm_q[0];

	pmsc_chan_store #(
		.CHANNELS (CHANNELS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (st_rd_en),
		.rd_idx  (idx_lut[s_axis_tdata[3:0]]),
		.rd_word (st_rd_word),
		.wr_en   (st_wr_en),
		.wr_idx  (idx_q),
		.wr_word (st_wr_word)
	);

	pmsc_serial_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_go_q),
		.op_a    (mul_a_q),
		.op_b    (mul_b_q),
		.done    (mul_done),
		.product (mul_p)
	);

	pmsc_serial_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_go_q),
		.dividend  (div_n_q),
		.divisor   (div_d_q),
		.done      (div_done),
		.quotient  (div_q),
		.remainder (div_r)
	);

	// ---------------- datapath helpers ----------------
	assign g_rst   = pmsc_pkg::schmitt(st_rd_word.rst_armed, rst_mv_q);
	assign g_inc   = pmsc_pkg::schmitt(st_rd_word.inc_armed, inc_mv_q);
	assign g_dec   = pmsc_pkg::schmitt(st_rd_word.dec_armed, dec_mv_q);
	assign n_eff   = (steps_count_q == '0) ? SW'(1) : steps_count_q;
	assign scl_mag = scl_mv_q[MW-1] ? (~scl_mv_q + 1'b1) : scl_mv_q;
	assign size_mag = div_q[MW-1:0];

	assign size_ext = {size_q[MW-1], size_q};

	always_comb begin
		if (fi_q && !fd_q)      delta = size_ext;
		else if (fd_q && !fi_q) delta = -size_ext;
		else                    delta = '0;
	end

	assign sum     = $signed({6'b0, step_q}) + delta;
	assign sum_mag = sum[15] ? 16'(-sum) : 16'(sum);
	assign rem_s   = div_r[SW-1:0];
	assign twice   = {step_q, half_step_q};

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
		end else begin
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (st_rd_en) state_q <= ST_READ;
				end
				ST_READ: begin
					if (!present_q) begin
						state_q <= ST_SUM;
					end else if (scale_rel_q) begin
						mul_go_q <= 1'b1;
						state_q  <= ST_SZ_MUL;
					end else begin
						div_go_q <= 1'b1;
						state_q  <= ST_SZ_DIV;
					end
				end
				ST_SZ_MUL: begin
					if (mul_done) begin
						div_go_q <= 1'b1;
						state_q  <= ST_SZ_DIV;
					end
				end
				ST_SZ_DIV: begin
					if (div_done) state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (fr_q) begin
						state_q <= ST_LEVEL;
					end else begin
						div_go_q <= 1'b1;
						state_q  <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (div_done) state_q <= ST_LEVEL;
				end
				ST_LEVEL: begin
					mul_go_q <= 1'b1;
					state_q  <= ST_LV_MUL;
				end
				ST_LV_MUL: begin
					if (mul_done) begin
						if (per_step_q) begin
							state_q <= ST_FINISH;
						end else begin
							div_go_q <= 1'b1;
							state_q  <= ST_LV_DIV;
						end
					end
				end
				ST_LV_DIV: begin
					if (div_done) state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload and operand registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (st_rd_en) begin
					chan_q    <= s_axis_tdata[3:0];
					idx_q     <= idx_lut[s_axis_tdata[3:0]];
					rst_mv_q  <= s_axis_tdata[18:4];
					inc_mv_q  <= s_axis_tdata[33:19];
					dec_mv_q  <= s_axis_tdata[48:34];
					scl_mv_q  <= s_axis_tdata[63:49];
					present_q <= s_axis_tuser;
				end
			end
			ST_READ: begin
				fr_q      <= g_rst.fire;
				fi_q      <= g_inc.fire;
				fd_q      <= g_dec.fire;
				arm_q     <= {g_rst.armed, g_inc.armed, g_dec.armed};
				step_q    <= st_rd_word.step;
				n_q       <= n_eff;
				scl_neg_q <= scl_mv_q[MW-1];
				size_q    <= MW'(1);
				mul_a_q   <= scl_mag;
				mul_b_q   <= pmsc_pkg::MUL_B_W'(n_eff);
				div_n_q   <= pmsc_pkg::DIV_N_W'(scl_mag);
				div_d_q   <= pmsc_pkg::SCALE_ABS_DIV;
			end
			ST_SZ_MUL: begin
				if (mul_done) begin
					div_n_q <= mul_p[pmsc_pkg::DIV_N_W-1:0];
					div_d_q <= pmsc_pkg::SCALE_REL_DIV;
				end
			end
			ST_SZ_DIV: begin
				if (div_done) size_q <= scl_neg_q ? MW'(-size_mag) : size_mag;
			end
			ST_SUM: begin
				sum_neg_q <= sum[15];
				div_n_q   <= pmsc_pkg::DIV_N_W'(sum_mag);
				div_d_q   <= pmsc_pkg::DIV_D_W'(n_q);
				if (fr_q) step_q <= '0;
			end
			ST_MOD: begin
				// C remainder follows the dividend's sign; fold into 0..n-1
				if (div_done) step_q <= (sum_neg_q && rem_s != '0) ? n_q - rem_s : rem_s;
			end
			ST_LEVEL: begin
				mul_a_q <= pmsc_pkg::MUL_A_W'(twice);
				mul_b_q <= per_step_q ? pmsc_pkg::LVL_PER_STEP : pmsc_pkg::LVL_FULL_SCALE;
			end
			ST_LV_MUL: begin
				if (mul_done) begin
					level_q <= mul_p[pmsc_pkg::LEVEL_W-1:0];
					div_n_q <= mul_p[pmsc_pkg::DIV_N_W-1:0];
					div_d_q <= pmsc_pkg::DIV_D_W'({n_q, 1'b0});
				end
			end
			ST_LV_DIV: begin
				if (div_done) level_q <= div_q[pmsc_pkg::LEVEL_W-1:0];
			end
			default: ;
		endcase
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (st_wr_en) begin
			m_tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_wr_en) m_tdata_q <= {7'b0, level_q, size_q, step_q, chan_q};
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	// ---------------- assertions ----------------
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == ST_READ))
		else $error("accepted request did not start a store read");

	a_step_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		st_wr_en |-> (step_q < n_q))
		else $error("stored step not below step count");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		st_wr_en |=> m_axis_tvalid)
		else $error("finished request not presented on output");

endmodule
